FILE: rtl/ceb_pkg.sv
// ============================================================================
// Calendar epoch BCD converter package
// Shared constants, the month-start table builder, BCD helpers and the
// pipeline payload type.
// ============================================================================
package ceb_pkg;

    localparam int unsigned MaxYearCount    = 18;
    localparam int unsigned MonthsPerYear   = 12;
    localparam int unsigned RomDepth        = MaxYearCount * MonthsPerYear + 1;
    localparam int unsigned RomIdxW         = $clog2(RomDepth);
    localparam int unsigned FirstYear       = 2020;
    localparam int unsigned YearBase        = 20;
    localparam int unsigned DaysToFirstYear = 18262;
    localparam int unsigned SecPerDay       = 86400;
    localparam int unsigned SecPerHour      = 3600;
    localparam int unsigned SecPerMin       = 60;
    localparam int unsigned SummerOffset    = 18000;
    localparam int unsigned WinterOffset    = 21600;
    localparam int unsigned DataW           = 80;

    // Month-start words; the last entry is the limit after the final month.
    typedef logic [31:0] t_rom [RomDepth];

    typedef struct packed {
        logic        kind;
        logic        oor;
        logic [4:0]  yidx;
        logic [3:0]  mo;
        logic [7:0]  sec;
        logic [7:0]  min;
        logic [5:0]  hr;
        logic [7:0]  day;
        logic [31:0] acc;
        logic [31:0] base;
        logic [31:0] p_day;
        logic [17:0] p_hr;
        logic [13:0] p_ms;
        logic [21:0] rem;
    } t_pipe;

    function automatic logic is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_len(input int unsigned mon, input logic leap);
        int unsigned len;
        len = 31;
        if (mon == 1) begin
            len = leap ? 29 : 28;
        end else if (mon == 3 || mon == 5 || mon == 8 || mon == 10) begin
            len = 30;
        end
        return len;
    endfunction

    function automatic t_rom build_rom();
        t_rom        rom;
        int unsigned days;
        int unsigned yr;
        int unsigned mon;
        days = DaysToFirstYear;
        for (int unsigned idx = 0; idx < RomDepth; idx++) begin
            yr  = FirstYear + idx / MonthsPerYear;
            mon = idx % MonthsPerYear;
            rom[idx] = 32'(days * SecPerDay +
                           ((mon >= 3 && mon <= 10) ? SummerOffset : WinterOffset));
            days = days + month_len(mon, is_leap(yr));
        end
        return rom;
    endfunction

    // Each nibble weighs in without a digit check, so 0x1A reads as 20.
    function automatic logic [7:0] bcd_dec(input logic [7:0] b);
        return 8'({4'd0, b[7:4]} * 8'd10 + {4'd0, b[3:0]});
    endfunction

    function automatic logic [7:0] bcd_enc(input logic [5:0] v);
        logic [3:0] tens;
        logic [5:0] ones;
        tens = 4'd0;
        for (int k = 1; k <= 5; k++) begin
            if (v >= 6'(10 * k)) begin
                tens = 4'(k);
            end
        end
        ones = v - 6'({2'd0, tens} * 6'd10);
        return {tens, ones[3:0]};
    endfunction

endpackage

FILE: rtl/calendar_epoch_bcd_converter.sv
// ============================================================================
// Calendar epoch BCD converter
// Converts a BCD real-time-clock reading to 32-bit epoch seconds and back.
// ============================================================================
// The block takes one conversion per clock while its output is not stalled,
// and passes each result through six pipeline stages and an output
// register. Stage one decodes the BCD fields or finds the year of an epoch,
// stage two forms the product terms or finds the month, stage three sums the
// terms or takes the remainder from the month start, and stages four to six
// split that remainder into days, hours and minutes by compare-and-subtract.
// The 217-word month-start table is constant logic built at elaboration, so
// no memory or clearing pass is involved. Each stage holds its item while the
// next stage is full, so a stalled output loses nothing and empty stages
// still fill. Out-of-table years, months or epochs return only the
// out-of-range flag with all data zero.
module calendar_epoch_bcd_converter #(
    parameter int unsigned YEAR_COUNT = ceb_pkg::MaxYearCount
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // epoch_in[31:0], bcd_second, bcd_minute, bcd_hour, bcd_day, bcd_month,
    // bcd_year (8 bits each, upward from bit 32)
    input  logic [ceb_pkg::DataW-1:0]  i_s_axis_tdata,
    // kind
    input  logic                       i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // epoch_out[31:0], second_out, minute_out, hour_out, day_out, month_out,
    // year_out (8 bits each, upward from bit 32)
    output logic [ceb_pkg::DataW-1:0]  o_m_axis_tdata,
    // out_of_range
    output logic                       o_m_axis_tuser
);
    import ceb_pkg::*;

    localparam int unsigned NumStages  = 6;
    localparam int unsigned MonthCount = YEAR_COUNT * MonthsPerYear;
    localparam t_rom        MonthRom   = build_rom();

    t_pipe                  r_pipe [NumStages];
    t_pipe                  n_pipe [NumStages];
    logic [NumStages-1:0]   r_vld;
    logic [NumStages:0]     w_en;
    logic                   r_out_vld;
    logic [DataW-1:0]       r_out_data;
    logic                   r_out_oor;
    logic [DataW-1:0]       n_out_data;

    // A stage may load whenever it is empty or the stage after it moves.
    always_comb begin
        w_en[NumStages] = !r_out_vld || i_m_axis_tready;
        for (int k = NumStages - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_s_axis_tready = w_en[0];

    // Stage one: decode the BCD fields and range-check them, or range-check
    // the epoch and find its year by comparing against the year starts.
    always_comb begin
        logic [7:0] d_mon;
        logic [7:0] d_yr;
        logic       oor0;
        logic       oor1;
        logic [31:0] et;
        n_pipe[0]      = '0;
        et             = i_s_axis_tdata[31:0];
        d_mon          = bcd_dec(i_s_axis_tdata[71:64]);
        d_yr           = bcd_dec(i_s_axis_tdata[79:72]);
        n_pipe[0].kind = i_s_axis_tuser;
        n_pipe[0].acc  = et;
        n_pipe[0].sec  = bcd_dec(i_s_axis_tdata[39:32]);
        n_pipe[0].min  = bcd_dec(i_s_axis_tdata[47:40]);
        n_pipe[0].hr   = 6'({4'd0, i_s_axis_tdata[53:52]} * 6'd10 +
                            {2'd0, i_s_axis_tdata[51:48]});
        n_pipe[0].day  = bcd_dec(i_s_axis_tdata[63:56]);
        oor0 = (d_yr < 8'(YearBase)) || (d_yr >= 8'(YearBase + YEAR_COUNT)) ||
               (d_mon < 8'd1) || (d_mon > 8'(MonthsPerYear));
        oor1 = (et < MonthRom[0]) || (et >= MonthRom[MonthCount]);
        if (i_s_axis_tuser) begin
            n_pipe[0].oor = oor1;
            for (int y = 1; y < int'(YEAR_COUNT); y++) begin
                if (et >= MonthRom[y * MonthsPerYear]) begin
                    n_pipe[0].yidx = 5'(y);
                end
            end
        end else begin
            n_pipe[0].oor = oor0;
            if (!oor0) begin
                n_pipe[0].yidx = 5'(d_yr - 8'(YearBase));
                n_pipe[0].mo   = 4'(d_mon - 8'd1);
            end
        end
    end

    // Stage two: product terms and month start for a BCD reading, or the
    // month of an epoch within its year.
    always_comb begin
        logic [RomIdxW-1:0] yb;
        n_pipe[1] = r_pipe[0];
        yb = RomIdxW'(r_pipe[0].yidx) * RomIdxW'(MonthsPerYear);
        if (r_pipe[0].kind) begin
            for (int m = 1; m < int'(MonthsPerYear); m++) begin
                if (r_pipe[0].acc >= MonthRom[yb + RomIdxW'(m)]) begin
                    n_pipe[1].mo = 4'(m);
                end
            end
        end else begin
            n_pipe[1].base  = MonthRom[yb + RomIdxW'(r_pipe[0].mo)];
            n_pipe[1].p_day = 32'(({24'd0, r_pipe[0].day} - 32'd1) * 32'(SecPerDay));
            n_pipe[1].p_hr  = 18'({12'd0, r_pipe[0].hr} * 18'(SecPerHour));
            n_pipe[1].p_ms  = 14'({6'd0, r_pipe[0].min} * 14'(SecPerMin) +
                                  {6'd0, r_pipe[0].sec});
        end
    end

    // Stage three: sum the terms, or take the offset into the month.
    always_comb begin
        logic [RomIdxW-1:0] mi;
        n_pipe[2] = r_pipe[1];
        mi = RomIdxW'(r_pipe[1].yidx) * RomIdxW'(MonthsPerYear) +
             RomIdxW'(r_pipe[1].mo);
        if (r_pipe[1].kind) begin
            n_pipe[2].rem = 22'(r_pipe[1].acc - MonthRom[mi]);
        end else begin
            n_pipe[2].acc = r_pipe[1].base + r_pipe[1].p_day +
                            {14'd0, r_pipe[1].p_hr} + {18'd0, r_pipe[1].p_ms};
        end
    end

    // Stage four: whole days.
    always_comb begin
        logic [21:0] r;
        logic [4:0]  q;
        n_pipe[3] = r_pipe[2];
        r = r_pipe[2].rem;
        q = '0;
        for (int i = 4; i >= 0; i--) begin
            if (r >= 22'(SecPerDay << i)) begin
                r    = r - 22'(SecPerDay << i);
                q[i] = 1'b1;
            end
        end
        if (r_pipe[2].kind) begin
            n_pipe[3].day = {3'd0, q};
            n_pipe[3].rem = r;
        end
    end

    // Stage five: hours.
    always_comb begin
        logic [16:0] r;
        logic [4:0]  q;
        n_pipe[4] = r_pipe[3];
        r = r_pipe[3].rem[16:0];
        q = '0;
        for (int i = 4; i >= 0; i--) begin
            if (r >= 17'(SecPerHour << i)) begin
                r    = r - 17'(SecPerHour << i);
                q[i] = 1'b1;
            end
        end
        if (r_pipe[3].kind) begin
            n_pipe[4].hr  = {1'b0, q};
            n_pipe[4].rem = {5'd0, r};
        end
    end

    // Stage six: minutes, leaving the seconds.
    always_comb begin
        logic [11:0] r;
        logic [5:0]  q;
        n_pipe[5] = r_pipe[4];
        r = r_pipe[4].rem[11:0];
        q = '0;
        for (int i = 5; i >= 0; i--) begin
            if (r >= 12'(SecPerMin << i)) begin
                r    = r - 12'(SecPerMin << i);
                q[i] = 1'b1;
            end
        end
        if (r_pipe[4].kind) begin
            n_pipe[5].min = {2'd0, q};
            n_pipe[5].sec = {2'd0, r[5:0]};
        end
    end

    // Output formatting: BCD encoding for epoch input, zeros when out of range.
    always_comb begin
        n_out_data = '0;
        if (!r_pipe[5].oor) begin
            if (r_pipe[5].kind) begin
                n_out_data[39:32] = bcd_enc(r_pipe[5].sec[5:0]);
                n_out_data[47:40] = bcd_enc(r_pipe[5].min[5:0]);
                n_out_data[55:48] = bcd_enc(r_pipe[5].hr);
                n_out_data[63:56] = bcd_enc(6'(r_pipe[5].day) + 6'd1);
                n_out_data[71:64] = bcd_enc({2'd0, r_pipe[5].mo} + 6'd1);
                n_out_data[79:72] = bcd_enc({1'b0, r_pipe[5].yidx} + 6'(YearBase));
            end else begin
                n_out_data[31:0] = r_pipe[5].acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < int'(NumStages); k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (w_en[NumStages]) begin
                r_out_vld <= r_vld[NumStages-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < int'(NumStages); k++) begin
            if (w_en[k]) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
        if (w_en[NumStages]) begin
            r_out_data <= n_out_data;
            r_out_oor  <= r_pipe[NumStages-1].oor;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_oor;

`ifndef SYNTHESIS
    a_oor_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_oor) |-> (r_out_data == '0))
        else $error("out-of-range result carries data");

    a_last_stage_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NumStages-1] && !w_en[NumStages]) |=> r_vld[NumStages-1])
        else $error("item dropped from last stage");

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> ((&r_vld) && r_out_vld))
        else $error("input stalled with room in pipeline");

    a_remainder_in_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && r_pipe[3].kind && !r_pipe[3].oor) |->
            (r_pipe[3].rem < 22'(SecPerDay)))
        else $error("day split left remainder of a day or more");
`endif

endmodule

FILE: tb/sv/testbench.sv
// ============================================================================
// Calendar epoch BCD converter testbench
// Drives BCD-to-epoch and epoch-to-BCD conversions through the stream ports,
// predicts each result with an independent calendar model and compares every
// output transfer field by field, in order, under random stalls on both sides.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    import ceb_pkg::*;

    localparam int unsigned NumYears   = 18;
    localparam int unsigned NumMonths  = NumYears * 12;
    localparam int unsigned NumRandom  = 400;
    localparam longint      CycleLimit = 400000;

    // Conversion direction carried on the input tuser bit.
    typedef enum logic {
        KIND_BCD_TO_EPOCH = 1'b0,
        KIND_EPOCH_TO_BCD = 1'b1
    } t_kind;

    typedef struct packed {
        logic [7:0]  year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
        logic [31:0] epoch;
    } t_fields;

    typedef struct {
        t_kind   kind;
        t_fields data;
    } t_request;

    typedef struct {
        logic    oor;
        t_fields data;
    } t_answer;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_tvalid;
    logic                s_tready;
    // epoch_in, bcd_second, bcd_minute, bcd_hour, bcd_day, bcd_month, bcd_year
    logic [DataW-1:0]    s_tdata;
    // kind
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    // epoch_out, second_out, minute_out, hour_out, day_out, month_out, year_out
    logic [DataW-1:0]    m_tdata;
    // out_of_range
    logic                m_tuser;

    t_request   pending_requests[$];
    t_answer    expected_answers[$];
    logic [31:0] month_starts[NumMonths + 1];

    int  mismatch_count;
    int  result_count;
    int  oor_count;
    int  to_epoch_count;
    int  to_bcd_count;
    int  send_gap;
    int  recv_gap;
    bit  stimulus_done;
    bit  hold_for_drain;
    longint cycle_count;

    calendar_epoch_bcd_converter #(.YEAR_COUNT(NumYears)) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Month-start table built by counting days year by year from 1970.
    function automatic bit leap_year(int unsigned y);
        return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
        int unsigned lengths[12];
        lengths = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        return (m == 1 && leap_year(y)) ? 29 : lengths[m];
    endfunction

    initial begin
        longint unsigned day_number;
        int unsigned     y;
        day_number = 0;
        for (y = 1970; y < 2020; y++) day_number += leap_year(y) ? 366 : 365;
        for (int i = 0; i <= NumMonths; i++) begin
            // April through November use the shorter local offset.
            month_starts[i] = 32'(day_number * 86400 +
                                  ((i % 12 >= 3 && i % 12 <= 10) ? 18000 : 21600));
            day_number += days_in_month(i % 12, 2020 + i / 12);
        end
    end

    function automatic int unsigned digits_value(logic [7:0] b);
        return b[7:4] * 10 + b[3:0];
    endfunction

    function automatic logic [7:0] digits_of(int unsigned v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    // Expected converter output for one request.
    function automatic t_answer convert_time(t_request req);
        t_answer     ans;
        int unsigned yr, mo, idx, rest, tod;
        logic [31:0] sum;
        ans.oor  = 1'b0;
        ans.data = '0;
        if (req.kind == KIND_BCD_TO_EPOCH) begin
            yr = digits_value(req.data.year);
            mo = digits_value(req.data.month);
            if (yr < 20 || yr >= 20 + NumYears || mo < 1 || mo > 12) begin
                ans.oor = 1'b1;
            end else begin
                sum = month_starts[(yr - 20) * 12 + mo - 1];
                sum += 32'(86400) * (32'(digits_value(req.data.day)) - 32'd1);
                sum += 32'(3600 * (req.data.hour[5:4] * 10 + req.data.hour[3:0]));
                sum += 32'(60 * digits_value(req.data.minute));
                sum += 32'(digits_value(req.data.second));
                ans.data.epoch = sum;
            end
        end else if (req.data.epoch < month_starts[0] ||
                     req.data.epoch >= month_starts[NumMonths]) begin
            ans.oor = 1'b1;
        end else begin
            idx = 0;
            while (month_starts[idx + 1] <= req.data.epoch) idx++;
            rest = req.data.epoch - month_starts[idx];
            tod  = rest % 86400;
            ans.data.second = digits_of(tod % 60);
            ans.data.minute = digits_of((tod % 3600) / 60);
            ans.data.hour   = digits_of(tod / 3600);
            ans.data.day    = digits_of(1 + rest / 86400);
            ans.data.month  = digits_of(idx % 12 + 1);
            ans.data.year   = digits_of(20 + idx / 12);
        end
        return ans;
    endfunction

    function automatic t_request bcd_request(logic [7:0] ss, logic [7:0] mm, logic [7:0] hh,
                                             logic [7:0] dd, logic [7:0] mo, logic [7:0] yy);
        t_request r;
        r.kind = KIND_BCD_TO_EPOCH;
        r.data = {yy, mo, dd, hh, mm, ss, 32'($urandom)};
        return r;
    endfunction

    function automatic t_request epoch_request(logic [31:0] e);
        t_request r;
        r.kind = KIND_EPOCH_TO_BCD;
        r.data = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), e};
        return r;
    endfunction

    function automatic logic [7:0] valid_digits(int unsigned lo, int unsigned hi);
        return digits_of($urandom_range(hi, lo));
    endfunction

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50) return 0;
        if (roll < 90) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // Stimulus: directed corners first, then a random mix.
    initial begin
        int unsigned m;
        stimulus_done  = 1'b0;
        hold_for_drain = 1'b0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pending_requests.push_back(bcd_request(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h20));
        pending_requests.push_back(bcd_request(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h37));
        pending_requests.push_back(bcd_request(8'hff, 8'hff, 8'hff, 8'hff, 8'h12, 8'h37));
        pending_requests.push_back(bcd_request(8'h1a, 8'h2f, 8'hcf, 8'h00, 8'h06, 8'h25));
        pending_requests.push_back(bcd_request(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h19));
        pending_requests.push_back(bcd_request(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h38));
        pending_requests.push_back(bcd_request(8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h30));
        pending_requests.push_back(bcd_request(8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h30));
        pending_requests.push_back(bcd_request(8'h00, 8'h00, 8'h00, 8'h01, 8'h0b, 8'h1f));
        pending_requests.push_back(epoch_request(32'h0000_0000));
        pending_requests.push_back(epoch_request(32'hffff_ffff));
        pending_requests.push_back(epoch_request(month_starts[0] - 1));
        pending_requests.push_back(epoch_request(month_starts[0]));
        pending_requests.push_back(epoch_request(month_starts[NumMonths] - 1));
        pending_requests.push_back(epoch_request(month_starts[NumMonths]));
        pending_requests.push_back(epoch_request(month_starts[3] - 1));
        pending_requests.push_back(epoch_request(month_starts[3]));
        pending_requests.push_back(epoch_request(month_starts[26] + 86399));

        for (int n = 0; n < NumRandom; n++) begin
            // Halfway through, let the pipeline drain completely once.
            if (n == NumRandom / 2) begin
                wait (pending_requests.size() == 0 && !s_tvalid);
                hold_for_drain = 1'b1;
                wait (expected_answers.size() == 0);
                @(posedge i_clk);
                hold_for_drain = 1'b0;
            end
            case ($urandom_range(9))
                0: pending_requests.push_back(epoch_request($urandom));
                1: pending_requests.push_back(bcd_request(8'($urandom), 8'($urandom),
                                                          8'($urandom), 8'($urandom),
                                                          8'($urandom), 8'($urandom)));
                2, 3, 4: begin
                    m = $urandom_range(NumMonths - 1);
                    pending_requests.push_back(epoch_request(month_starts[m] +
                        $urandom_range(month_starts[m + 1] - month_starts[m] - 1)));
                end
                5: begin
                    m = $urandom_range(NumMonths);
                    pending_requests.push_back(epoch_request(month_starts[m] +
                        $urandom_range(2) - 1));
                end
                default: pending_requests.push_back(bcd_request(
                    valid_digits(0, 59), valid_digits(0, 59),
                    {2'($urandom), 6'(valid_digits(0, 23))},
                    valid_digits(1, 31), valid_digits(1, 12), valid_digits(20, 37)));
            endcase
        end
        stimulus_done = 1'b1;
    end

    // Driver: holds tvalid until the transfer, then moves to the next item.
    always @(posedge i_clk) begin
        t_request req;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            send_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                req.kind = t_kind'(s_tuser);
                req.data = s_tdata;
                expected_answers.push_back(convert_time(req));
                if (req.kind == KIND_BCD_TO_EPOCH) to_epoch_count++;
                else to_bcd_count++;
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0 && !hold_for_drain) begin
                req = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= req.data;
                s_tuser  <= req.kind;
                send_gap <= gap_length();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure and in-order comparison.
    always @(posedge i_clk) begin
        t_answer exp_ans;
        t_fields got;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                result_count++;
                if (m_tuser) oor_count++;
                if (expected_answers.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: tdata=%h oor=%b", m_tdata, m_tuser);
                end else begin
                    exp_ans = expected_answers.pop_front();
                    if (got !== exp_ans.data || m_tuser !== exp_ans.oor) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected tdata=%h oor=%b, got tdata=%h oor=%b",
                                     exp_ans.data, exp_ans.oor, m_tdata, m_tuser);
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                recv_gap <= gap_length();
            end
        end
    end

    initial begin
        mismatch_count = 0;
        result_count   = 0;
        oor_count      = 0;
        to_epoch_count = 0;
        to_bcd_count   = 0;
        cycle_count    = 0;
        wait (stimulus_done && pending_requests.size() == 0 && !s_tvalid &&
              expected_answers.size() == 0);
        repeat (20) @(posedge i_clk);
        $display("Converted %0d clock readings to epoch and %0d epochs to clock readings.",
                 to_epoch_count, to_bcd_count);
        $display("Checked %0d results, %0d of them out of range.", result_count, oor_count);
        if (mismatch_count == 0 && expected_answers.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

endmodule

FILE: sim.f
rtl/ceb_pkg.sv
rtl/calendar_epoch_bcd_converter.sv
tb/sv/testbench.sv
